// File: sv/open_order_tracking_table_core_assert.svh
// Assertion macros shared by the table core.
`ifndef OPEN_ORDER_TRACKING_TABLE_CORE_ASSERT_SVH
`define OPEN_ORDER_TRACKING_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OOTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("table core assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OOTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("table core assertion failed");

`endif

// File: sv/oott_pkg.sv
`timescale 1ns / 1ps
package oott_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] OP_ORDER_ACK = 2'd0;
  localparam logic [1:0] OP_TRADE = 2'd1;
  localparam logic [1:0] OP_CANCEL_ACK = 2'd2;
  localparam logic [1:0] OP_MODIFY_ACK = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_OVERFILL = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic accepted;
    logic [63:0] order_id;
    logic [63:0] new_order_id;
    logic [31:0] quantity;
    logic [31:0] price;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic entry_found;
    logic entry_removed;
    logic [31:0] remaining_qty;
    logic [6:0] entry_count;
  } result_t;

  typedef struct packed {
    logic active;
    logic found;
    logic [IDX_W-1:0] hit_slot;
    logic [31:0] hit_qty;
    logic other;
    logic free;
    logic [IDX_W-1:0] free_slot;
  } token_t;

  typedef struct packed {
    logic en;
    logic [IDX_W-1:0] slot;
    logic set_valid;
    logic clr_valid;
    logic wr_key;
    logic wr_qty;
    logic wr_price;
    logic [63:0] key;
    logic [31:0] qty;
    logic [31:0] price;
  } write_cmd_t;

endpackage

// File: sv/oott_cell.sv
`timescale 1ns / 1ps
module oott_cell
  import oott_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic [IDX_W-1:0] idx,
  input  request_t req,
  input  write_cmd_t cmd,
  input  token_t tok_in,
  output token_t tok_out
);

  logic valid;
  logic [63:0] key;
  logic [31:0] qty;
  logic [31:0] price;
  logic hit;
  logic other_hit;
  token_t tok_next;
  logic sel;

  assign hit = valid && (key == req.order_id);
  assign other_hit = valid && (key == req.new_order_id);
  assign sel = cmd.en && (cmd.slot == idx);

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found && hit) begin
      tok_next.found = 1'b1;
      tok_next.hit_slot = idx;
      tok_next.hit_qty = qty;
    end
    if (other_hit) begin
      tok_next.other = 1'b1;
    end
    if (!tok_in.free && !valid) begin
      tok_next.free = 1'b1;
      tok_next.free_slot = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.wr_key) begin
      key <= cmd.key;
    end
    if (sel && cmd.wr_qty) begin
      qty <= cmd.qty;
    end
    if (sel && cmd.wr_price) begin
      price <= cmd.price;
    end
    if (rst) begin
      tok_out <= '0;
      valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (sel && cmd.clr_valid) begin
        valid <= 1'b0;
      end else if (sel && cmd.set_valid) begin
        valid <= 1'b1;
      end
    end
  end

endmodule

// File: sv/open_order_tracking_table_core.sv
`timescale 1ns / 1ps
// An event is taken only in IDLE; request_stall holds off the next one until the result is registered.
// A search token walks the row of cells, one cell per cycle; the SEARCH state then registers
// the decision, and the COMMIT state writes back the table once the result output is free.
// Reset (synchronous, active high) empties the table and clears the handshakes at once.
module open_order_tracking_table_core
  import oott_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic request_valid,
  output logic request_stall,
  input  request_t request,
  output logic result_valid,
  input  logic result_stall,
  output result_t result
);

  typedef enum logic [1:0] {IDLE, SEARCH, COMMIT} state_t;

  state_t state;
  request_t req;
  token_t inj;
  token_t link [0:ENTRIES];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] cnt_hold;
  result_t res;
  result_t res_next;
  write_cmd_t cmd;
  write_cmd_t cmd_next;
  write_cmd_t cmd_bus;
  token_t tk;
  logic go;
  logic [31:0] diff;

  assign link[0] = inj;
  assign tk = link[ENTRIES];
  assign request_stall = (state != IDLE);
  assign go = (state == COMMIT) && (!result_valid || !result_stall);

  always_comb begin
    cmd_bus = cmd;
    cmd_bus.en = go;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    oott_cell u_cell (
      .clk(clk),
      .rst(rst),
      .idx(IDX_W'(i)),
      .req(req),
      .cmd(cmd_bus),
      .tok_in(link[i]),
      .tok_out(link[i+1])
    );
  end

  always_comb begin
    diff = tk.hit_qty - req.quantity;
    cnt_next = count;
    res_next = '0;
    res_next.status = ST_OK;
    cmd_next = '0;
    cmd_next.slot = tk.hit_slot;
    cmd_next.key = req.order_id;
    cmd_next.qty = req.quantity;
    cmd_next.price = req.price;
    if (req.operation != OP_TRADE && !req.accepted) begin
      res_next.status = ST_IGNORED;
    end else begin
      res_next.entry_found = tk.found;
      unique case (req.operation)
        OP_ORDER_ACK: begin
          if (req.price == 32'd0) begin
            res_next.remaining_qty = tk.found ? tk.hit_qty : 32'd0;
          end else if (tk.found) begin
            cmd_next.wr_qty = 1'b1;
            cmd_next.wr_price = 1'b1;
            res_next.remaining_qty = req.quantity;
          end else if (tk.free) begin
            cmd_next.slot = tk.free_slot;
            cmd_next.set_valid = 1'b1;
            cmd_next.wr_key = 1'b1;
            cmd_next.wr_qty = 1'b1;
            cmd_next.wr_price = 1'b1;
            cnt_next = count + 1'b1;
            res_next.remaining_qty = req.quantity;
          end else begin
            res_next.status = ST_FULL;
          end
        end
        OP_TRADE: begin
          if (!tk.found) begin
            res_next.status = ST_NOT_FOUND;
          end else if (req.quantity > tk.hit_qty) begin
            res_next.status = ST_OVERFILL;
            res_next.entry_removed = 1'b1;
            cmd_next.clr_valid = 1'b1;
            cnt_next = count - 1'b1;
          end else if (diff == 32'd0) begin
            res_next.entry_removed = 1'b1;
            cmd_next.clr_valid = 1'b1;
            cnt_next = count - 1'b1;
          end else begin
            res_next.remaining_qty = diff;
            cmd_next.wr_qty = 1'b1;
            cmd_next.qty = diff;
          end
        end
        OP_CANCEL_ACK: begin
          if (!tk.found) begin
            res_next.status = ST_NOT_FOUND;
          end else begin
            res_next.entry_removed = 1'b1;
            cmd_next.clr_valid = 1'b1;
            cnt_next = count - 1'b1;
          end
        end
        OP_MODIFY_ACK: begin
          if (!tk.found) begin
            res_next.status = ST_NOT_FOUND;
          end else if (req.new_order_id != req.order_id && tk.other) begin
            res_next.entry_removed = 1'b1;
            cmd_next.clr_valid = 1'b1;
            cnt_next = count - 1'b1;
          end else begin
            cmd_next.wr_key = 1'b1;
            cmd_next.key = req.new_order_id;
            cmd_next.wr_qty = 1'b1;
            cmd_next.wr_price = 1'b1;
            res_next.remaining_qty = req.quantity;
          end
        end
        default: begin
          res_next.status = ST_IGNORED;
        end
      endcase
    end
    res_next.entry_count = 7'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      inj <= '0;
      count <= '0;
      result_valid <= 1'b0;
    end else begin
      inj.active <= (state == IDLE) && request_valid;
      if (go) begin
        result <= res;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (request_valid) begin
            req <= request;
            state <= SEARCH;
          end
        end
        SEARCH: begin
          if (tk.active) begin
            res <= res_next;
            cmd <= cmd_next;
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (go) begin
            count <= cnt_hold;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_hold <= '0;
    end else if (state == SEARCH && tk.active) begin
      cnt_hold <= cnt_next;
    end
  end

  `include "open_order_tracking_table_core_assert.svh"

  `OOTT_ASSERT_SAME(a_count_range, 1'b1, count <= CNT_W'(ENTRIES))
  `OOTT_ASSERT_SAME(a_token_in_search, tk.active, state == SEARCH)
  `OOTT_ASSERT_NEXT(a_commit_done, go, state == IDLE && result_valid)
  `OOTT_ASSERT_SAME(a_ignored_clean, result_valid && result.status == ST_IGNORED,
                    !result.entry_found && !result.entry_removed)

endmodule

// File: dv/open_order_tracking_table_core_tb.sv
`timescale 1ns / 1ps
module open_order_tracking_table_core_tb;
  import oott_pkg::*;

  logic clk;
  logic rst;
  logic request_valid;
  logic request_stall;
  request_t request;
  logic result_valid;
  logic result_stall;
  result_t result;

  open_order_tracking_table_core u_top (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .request(request),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  logic        tbl_valid [ENTRIES];
  logic [63:0] tbl_key [ENTRIES];
  logic [31:0] tbl_qty [ENTRIES];
  logic [31:0] tbl_price [ENTRIES];
  int          tbl_count;

  request_t pending_events[$];
  result_t  expected_results[$];
  int       error_count;
  int       send_idle_pct;
  int       stall_pct;
  logic     all_queued;
  logic [63:0] id_pool [16];

  function automatic void queue_event(request_t ev);
    pending_events = {pending_events, ev};
  endfunction

  function automatic int find_order(logic [63:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int find_free_slot();
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tbl_valid[i]) return i;
    end
    return -1;
  endfunction

  function automatic result_t apply_event(request_t ev);
    result_t r;
    int slot;
    int other;
    r = '0;
    r.status = ST_OK;
    if (ev.operation != OP_TRADE && !ev.accepted) begin
      r.status = ST_IGNORED;
    end else begin
      slot = find_order(ev.order_id);
      r.entry_found = (slot >= 0);
      if (ev.operation == OP_ORDER_ACK) begin
        if (ev.price == 0) begin
          if (slot >= 0) r.remaining_qty = tbl_qty[slot];
        end else begin
          if (slot < 0) begin
            slot = find_free_slot();
            if (slot >= 0) begin
              tbl_valid[slot] = 1'b1;
              tbl_key[slot] = ev.order_id;
              tbl_count++;
            end
          end
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_qty[slot] = ev.quantity;
            tbl_price[slot] = ev.price;
            r.remaining_qty = ev.quantity;
          end
        end
      end else if (slot < 0) begin
        r.status = ST_NOT_FOUND;
      end else if (ev.operation == OP_TRADE) begin
        if (ev.quantity > tbl_qty[slot]) begin
          r.status = ST_OVERFILL;
          tbl_valid[slot] = 1'b0;
          tbl_count--;
          r.entry_removed = 1'b1;
        end else begin
          tbl_qty[slot] = tbl_qty[slot] - ev.quantity;
          r.remaining_qty = tbl_qty[slot];
          if (tbl_qty[slot] == 0) begin
            tbl_valid[slot] = 1'b0;
            tbl_count--;
            r.entry_removed = 1'b1;
          end
        end
      end else if (ev.operation == OP_CANCEL_ACK) begin
        tbl_valid[slot] = 1'b0;
        tbl_count--;
        r.entry_removed = 1'b1;
      end else begin
        other = (ev.new_order_id == ev.order_id) ? -1 : find_order(ev.new_order_id);
        if (other >= 0) begin
          tbl_valid[slot] = 1'b0;
          tbl_count--;
          r.entry_removed = 1'b1;
        end else begin
          tbl_key[slot] = ev.new_order_id;
          tbl_qty[slot] = ev.quantity;
          tbl_price[slot] = ev.price;
          r.remaining_qty = ev.quantity;
        end
      end
    end
    r.entry_count = tbl_count[6:0];
    return r;
  endfunction

  function automatic request_t make_event(logic [1:0] op, logic acc, logic [63:0] id,
                                          logic [63:0] nid, logic [31:0] q, logic [31:0] p);
    request_t ev;
    ev.operation = op;
    ev.accepted = acc;
    ev.order_id = id;
    ev.new_order_id = nid;
    ev.quantity = q;
    ev.price = p;
    return ev;
  endfunction

  function automatic logic [31:0] rand_qty();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic logic [63:0] rand_id();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return id_pool[4'($urandom_range(0, 15))];
  endfunction

  function automatic request_t random_event();
    logic [1:0] op;
    logic acc;
    logic [31:0] p;
    op = 2'($urandom_range(0, 3));
    if (op == OP_ORDER_ACK && $urandom_range(0, 2) != 0) op = OP_ORDER_ACK;
    acc = ($urandom_range(0, 9) != 0);
    p = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
    return make_event(op, acc, rand_id(), rand_id(), rand_qty(), p);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else if (!request_valid || !request_stall) begin
      if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        request <= pending_events.pop_front();
        request_valid <= 1'b1;
      end else begin
        request_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (request_valid && !request_stall) begin
        expected_results = {expected_results, apply_event(request)};
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          error_count++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (e !== result) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, result);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    request_valid = 1'b0;
    result_stall = 1'b0;
    request = '0;
    error_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    all_queued = 1'b0;
    tbl_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_qty[i] = '0;
      tbl_price[i] = '0;
    end
    for (int i = 0; i < 16; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = 64'd0;
    id_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd0, 64'd0, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd1));
    queue_event(make_event(OP_ORDER_ACK, 1'b0, 64'd5, 64'd0, 32'd3, 32'd3));
    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd0, 64'd0, 32'd9, 32'd0));
    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd7, 64'd0, 32'd9, 32'd0));
    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd0, 64'd0, 32'd10, 32'd4));
    queue_event(make_event(OP_TRADE, 1'b0, 64'd0, 64'd0, 32'd3, 32'd0));
    queue_event(make_event(OP_TRADE, 1'b1, 64'd0, 64'd0, 32'd7, 32'd0));
    queue_event(make_event(OP_TRADE, 1'b1, 64'd99, 64'd0, 32'd1, 32'd0));
    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd1, 64'd0, 32'd5, 32'd5));
    queue_event(make_event(OP_TRADE, 1'b1, 64'd1, 64'd0, 32'd6, 32'd0));
    queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd2, 64'd0, 32'd5, 32'd5));
    queue_event(make_event(OP_CANCEL_ACK, 1'b0, 64'd2, 64'd0, 32'd0, 32'd0));
    queue_event(make_event(OP_CANCEL_ACK, 1'b1, 64'd2, 64'd0, 32'd0, 32'd0));
    queue_event(make_event(OP_CANCEL_ACK, 1'b1, 64'd2, 64'd0, 32'd0, 32'd0));
    queue_event(make_event(OP_MODIFY_ACK, 1'b0, 64'd0, 64'd3, 32'd1, 32'd1));
    queue_event(make_event(OP_MODIFY_ACK, 1'b1, 64'd0, 64'd0, 32'd8, 32'd8));
    queue_event(make_event(OP_MODIFY_ACK, 1'b1, 64'd0, 64'd3, 32'd0, 32'd2));
    queue_event(make_event(OP_MODIFY_ACK, 1'b1, 64'd3,
                           64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd1));
    queue_event(make_event(OP_MODIFY_ACK, 1'b1, 64'd44, 64'd45, 32'd1, 32'd1));
    queue_event(make_event(OP_TRADE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
                           32'd0, 32'd0));
    for (int i = 0; i < 66; i++) begin
      queue_event(make_event(OP_ORDER_ACK, 1'b1, 64'd1000 + i, 64'd0, 32'd1, 32'd1));
    end

    for (int ph = 0; ph < 4; ph++) begin
      while (pending_events.size() > 0 || request_valid || expected_results.size() > 0)
        @(posedge clk);
      send_idle_pct <= (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 45) : 0;
      stall_pct <= (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 45) : 0;
      for (int k = 0; k < ENTRIES; k++) begin
        if (tbl_valid[k]) begin
          queue_event(make_event(OP_CANCEL_ACK, 1'b1, tbl_key[k], 64'd0, 32'd0, 32'd0));
        end
      end
      for (int i = 0; i < 320; i++) begin
        queue_event(random_event());
      end
    end
    all_queued = 1'b1;
  end

  initial begin
    wait (all_queued);
    while (pending_events.size() > 0 || request_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("open_order_tracking_table_core regression: pass");
    end else begin
      $display("open_order_tracking_table_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("open_order_tracking_table_core regression: fail");
    $finish;
  end

endmodule
